@@ sv/dfbs_pkg.sv @@
package dfbs_pkg;

  localparam int COORD_W = 24;
  localparam int TEXEL_W = 16;
  localparam int ADDR_W  = 16;
  localparam int DIM_W   = 9;
  localparam int FRAC_W  = 8;
  localparam int CFG_W   = 3;
  localparam int DATA_W  = 24;

  localparam logic [CFG_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_W-1:0] CFG_ORIGIN_X    = 3'd2;
  localparam logic [CFG_W-1:0] CFG_ORIGIN_Y    = 3'd3;
  localparam logic [CFG_W-1:0] CFG_SCALE_X     = 3'd4;
  localparam logic [CFG_W-1:0] CFG_SCALE_Y     = 3'd5;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic [3:0] load;
    logic       lerp;
  } blend_ctl_t;

endpackage

@@ sv/dfbs_if.sv @@
interface dfbs_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [dfbs_pkg::ADDR_W-1:0]         texel_index;
  logic signed [dfbs_pkg::TEXEL_W-1:0] texel_value;
  logic signed [dfbs_pkg::COORD_W-1:0] world_x;
  logic signed [dfbs_pkg::COORD_W-1:0] world_y;

  modport source (output valid, output operation, output texel_index, output texel_value,
                  output world_x, output world_y, input ready);
  modport sink (input valid, input operation, input texel_index, input texel_value,
                input world_x, input world_y, output ready);
endinterface

interface dfbs_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dfbs_pkg::TEXEL_W-1:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface

@@ sv/dfbs_mem.sv @@
module dfbs_mem (
  input  logic                         clk,
  input  logic                         we,
  input  logic [dfbs_pkg::ADDR_W-1:0]  addr,
  input  logic [dfbs_pkg::TEXEL_W-1:0] wdata,
  output logic [dfbs_pkg::TEXEL_W-1:0] rdata
);

  logic [dfbs_pkg::TEXEL_W-1:0] mem [2**dfbs_pkg::ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/dfbs_axis.sv @@
module dfbs_axis #(
  parameter int MAX_N = 256
) (
  input  logic                                clk,
  input  logic                                start,
  input  logic signed [dfbs_pkg::COORD_W-1:0] world,
  input  logic signed [dfbs_pkg::COORD_W-1:0] origin,
  input  logic [dfbs_pkg::COORD_W-1:0]        scale,
  input  logic [dfbs_pkg::DIM_W-1:0]          n,
  output logic [$clog2(MAX_N)-1:0]            whole,
  output logic [dfbs_pkg::FRAC_W-1:0]         frac
);

  localparam int CELL_W = $clog2(MAX_N);
  localparam int DIFF_W = dfbs_pkg::COORD_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int HI_W   = PROD_W - 1 - dfbs_pkg::COORD_W;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic [HI_W-1:0]          hi;
  logic [dfbs_pkg::DIM_W-1:0] n_last;

  always_ff @(posedge clk) begin
    if (start) begin
      diff <= DIFF_W'(world) - DIFF_W'(origin);
    end
    prod <= diff * $signed({1'b0, scale});
  end

  assign hi     = prod[PROD_W-2:dfbs_pkg::COORD_W];
  assign n_last = n - 1'b1;

  // Coordinates below the grid clamp to the first cell, beyond it to the last.
  always_ff @(posedge clk) begin
    priority if (prod[PROD_W-1]) begin
      whole <= '0;
      frac  <= '0;
    end else if (hi >= HI_W'(n_last)) begin
      whole <= CELL_W'(n_last);
      frac  <= '0;
    end else begin
      whole <= CELL_W'(hi);
      frac  <= prod[dfbs_pkg::COORD_W-1 -: dfbs_pkg::FRAC_W];
    end
  end

endmodule

@@ sv/dfbs_blend.sv @@
module dfbs_blend (
  input  logic                                clk,
  input  dfbs_pkg::blend_ctl_t                ctl,
  input  logic [dfbs_pkg::TEXEL_W-1:0]        rdata,
  input  logic [dfbs_pkg::FRAC_W-1:0]         fx,
  input  logic [dfbs_pkg::FRAC_W-1:0]         fy,
  output logic signed [dfbs_pkg::TEXEL_W-1:0] distance
);

  localparam int WGT_W = dfbs_pkg::FRAC_W + 1;
  localparam int ROW_W = dfbs_pkg::TEXEL_W + dfbs_pkg::FRAC_W;
  localparam int SUM_W = 2 * dfbs_pkg::TEXEL_W;

  logic [dfbs_pkg::TEXEL_W-1:0] biased;
  logic [dfbs_pkg::TEXEL_W-1:0] ta, tb, tc, td;
  logic [WGT_W-1:0]             wx0, wy0;
  logic [ROW_W-1:0]             top_row, bot_row;
  logic [SUM_W-1:0]             sum;

  // Texels are offset to unsigned so that the blend works on plain magnitudes.
  assign biased = rdata ^ {1'b1, {(dfbs_pkg::TEXEL_W-1){1'b0}}};
  assign wx0    = WGT_W'(2**dfbs_pkg::FRAC_W) - WGT_W'(fx);
  assign wy0    = WGT_W'(2**dfbs_pkg::FRAC_W) - WGT_W'(fy);

  always_ff @(posedge clk) begin
    if (ctl.load[0]) ta <= biased;
    if (ctl.load[1]) tb <= biased;
    if (ctl.load[2]) tc <= biased;
    if (ctl.load[3]) td <= biased;
    if (ctl.lerp) begin
      top_row <= ROW_W'(ROW_W'(ta) * ROW_W'(wx0) + ROW_W'(tb) * ROW_W'(fx));
      bot_row <= ROW_W'(ROW_W'(tc) * ROW_W'(wx0) + ROW_W'(td) * ROW_W'(fx));
    end
  end

  assign sum = SUM_W'(top_row) * SUM_W'(wy0) + SUM_W'(bot_row) * SUM_W'(fy)
             + SUM_W'(2**(SUM_W/2 - 1));
  assign distance = $signed(sum[SUM_W-1 -: dfbs_pkg::TEXEL_W]
                    ^ {1'b1, {(dfbs_pkg::TEXEL_W-1){1'b0}}});

endmodule

@@ sv/distance_field_bilinear_sampler.sv @@
// Bilinear sampler over a stored grid of Q8.8 signed distance texels.
// Items arrive on req. A write beat (operation 0) stores texel_value at
// texel_index and gives no result. A sample beat (operation 1)
// maps world_x/world_y into grid space, reads the four neighbor texels from
// the single-port texel memory one after another and delivers one distance
// beat on rsp.
// A sample runs through S_MAP1 and S_MAP2 (mapping), S_ROW, the four reads
// S_RD_A to S_RD_D and S_GET_D on the one memory port, S_LERP (blend) and
// S_DONE, where it loads the result register; the next item is accepted in
// the cycle after that. An empty grid goes from idle straight to S_DONE.
// While idle, writes are accepted back to back, one per cycle.
// The user must write configuration through cfg_write/cfg_index/cfg_data
// while idle, which the block does not enforce; unknown indexes are ignored.
// Reset clears the configuration registers and the handshake state; the
// texel memory is not cleared, and samples must read only written texels.
// The result stays in its register while rsp.ready is low. A new item is
// still accepted meanwhile, but a finished sample waits for the register.
module distance_field_bilinear_sampler #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [dfbs_pkg::CFG_W-1:0]          cfg_index,
  input  logic [dfbs_pkg::DATA_W-1:0]         cfg_data,
  dfbs_in_if.sink                             req,
  dfbs_out_if.source                          rsp
);

  localparam int XCELL_W = $clog2(MAX_WIDTH);
  localparam int YCELL_W = $clog2(MAX_HEIGHT);
  localparam int XCMP_W  = (XCELL_W > dfbs_pkg::DIM_W ? XCELL_W : dfbs_pkg::DIM_W) + 1;
  localparam int YCMP_W  = (YCELL_W > dfbs_pkg::DIM_W ? YCELL_W : dfbs_pkg::DIM_W) + 1;
  localparam int ROWP_W  = YCELL_W + dfbs_pkg::DIM_W;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_MAP1  = 11'b000_0000_0010,
    S_MAP2  = 11'b000_0000_0100,
    S_ROW   = 11'b000_0000_1000,
    S_RD_A  = 11'b000_0001_0000,
    S_RD_B  = 11'b000_0010_0000,
    S_RD_C  = 11'b000_0100_0000,
    S_RD_D  = 11'b000_1000_0000,
    S_GET_D = 11'b001_0000_0000,
    S_LERP  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state, state_next;

  logic [dfbs_pkg::DIM_W-1:0]          grid_width, grid_height;
  logic signed [dfbs_pkg::COORD_W-1:0] origin_x, origin_y;
  logic [dfbs_pkg::COORD_W-1:0]        scale_x, scale_y;

  logic [dfbs_pkg::DIM_W-1:0]  n_w, n_h;
  logic                        accept, sample_start, empty;
  logic [XCELL_W-1:0]          x0, x1;
  logic [YCELL_W-1:0]          y0, y1;
  logic [dfbs_pkg::FRAC_W-1:0] fx, fy;
  logic [ROWP_W-1:0]           row0_prod, row1_prod;
  logic [dfbs_pkg::ADDR_W-1:0] row0, row1, mem_addr;
  logic                        mem_we;
  logic [dfbs_pkg::TEXEL_W-1:0] mem_rdata;
  dfbs_pkg::blend_ctl_t        blend_ctl;
  logic signed [dfbs_pkg::TEXEL_W-1:0] blend_out;
  logic                        out_valid, out_load;
  logic signed [dfbs_pkg::TEXEL_W-1:0] out_distance;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= '0;
      grid_height <= '0;
      origin_x    <= '0;
      origin_y    <= '0;
      scale_x     <= '0;
      scale_y     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dfbs_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_data[dfbs_pkg::DIM_W-1:0];
        dfbs_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_data[dfbs_pkg::DIM_W-1:0];
        dfbs_pkg::CFG_ORIGIN_X:    origin_x    <= $signed(cfg_data);
        dfbs_pkg::CFG_ORIGIN_Y:    origin_y    <= $signed(cfg_data);
        dfbs_pkg::CFG_SCALE_X:     scale_x     <= cfg_data;
        dfbs_pkg::CFG_SCALE_Y:     scale_y     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n_w = (32'(grid_width) > MAX_WIDTH) ? dfbs_pkg::DIM_W'(MAX_WIDTH) : grid_width;
  assign n_h = (32'(grid_height) > MAX_HEIGHT) ? dfbs_pkg::DIM_W'(MAX_HEIGHT) : grid_height;

  assign req.ready    = (state == S_IDLE);
  assign accept       = req.valid && req.ready;
  assign sample_start = accept && (req.operation == dfbs_pkg::OP_SAMPLE);
  assign out_load     = (state == S_DONE) && (!out_valid || rsp.ready);

  dfbs_axis #(.MAX_N(MAX_WIDTH)) u_axis_x (
    .clk    (clk),
    .start  (sample_start),
    .world  (req.world_x),
    .origin (origin_x),
    .scale  (scale_x),
    .n      (n_w),
    .whole  (x0),
    .frac   (fx)
  );

  dfbs_axis #(.MAX_N(MAX_HEIGHT)) u_axis_y (
    .clk    (clk),
    .start  (sample_start),
    .world  (req.world_y),
    .origin (origin_y),
    .scale  (scale_y),
    .n      (n_h),
    .whole  (y0),
    .frac   (fy)
  );

  assign row0_prod = ROWP_W'(y0) * ROWP_W'(n_w);
  assign row1_prod = ROWP_W'(y1) * ROWP_W'(n_w);

  always_ff @(posedge clk) begin
    if (state == S_ROW) begin
      x1   <= (XCMP_W'(x0) + 1'b1 < XCMP_W'(n_w)) ? x0 + 1'b1 : x0;
      y1   <= (YCMP_W'(y0) + 1'b1 < YCMP_W'(n_h)) ? y0 + 1'b1 : y0;
      row0 <= dfbs_pkg::ADDR_W'(row0_prod);
    end
    if (state == S_RD_A) begin
      row1 <= dfbs_pkg::ADDR_W'(row1_prod);
    end
    if (sample_start) begin
      empty <= (n_w == '0) || (n_h == '0);
    end
  end

  always_comb begin
    mem_we = 1'b0;
    unique case (state)
      S_RD_A:  mem_addr = row0 + dfbs_pkg::ADDR_W'(x0);
      S_RD_B:  mem_addr = row0 + dfbs_pkg::ADDR_W'(x1);
      S_RD_C:  mem_addr = row1 + dfbs_pkg::ADDR_W'(x0);
      S_RD_D:  mem_addr = row1 + dfbs_pkg::ADDR_W'(x1);
      default: begin
        mem_addr = req.texel_index;
        mem_we   = accept && (req.operation == dfbs_pkg::OP_WRITE);
      end
    endcase
  end

  dfbs_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (req.texel_value),
    .rdata (mem_rdata)
  );

  assign blend_ctl.load = {state == S_GET_D, state == S_RD_D, state == S_RD_C, state == S_RD_B};
  assign blend_ctl.lerp = (state == S_LERP);

  dfbs_blend u_blend (
    .clk      (clk),
    .ctl      (blend_ctl),
    .rdata    (mem_rdata),
    .fx       (fx),
    .fy       (fy),
    .distance (blend_out)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (sample_start) begin
          state_next = ((n_w == '0) || (n_h == '0)) ? S_DONE : S_MAP1;
        end
      end
      S_MAP1:  state_next = S_MAP2;
      S_MAP2:  state_next = S_ROW;
      S_ROW:   state_next = S_RD_A;
      S_RD_A:  state_next = S_RD_B;
      S_RD_B:  state_next = S_RD_C;
      S_RD_C:  state_next = S_RD_D;
      S_RD_D:  state_next = S_GET_D;
      S_GET_D: state_next = S_LERP;
      S_LERP:  state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_distance <= empty ? '0 : blend_out;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.distance = out_distance;

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_load && empty |=> rsp.valid && (rsp.distance == '0))
    else $error("empty grid sample did not give zero");

  a_cell_in_grid: assert property (@(posedge clk) disable iff (rst)
    state == S_ROW |-> (XCMP_W'(x0) < XCMP_W'(n_w)) && (YCMP_W'(y0) < YCMP_W'(n_h)))
    else $error("mapped cell lies outside the grid");

  a_neighbor: assert property (@(posedge clk) disable iff (rst)
    state == S_RD_A |-> (x1 == x0 || XCMP_W'(x1) == XCMP_W'(x0) + 1'b1)
                     && (y1 == y0 || YCMP_W'(y1) == YCMP_W'(y0) + 1'b1))
    else $error("neighbor index is not the cell or the next one");

endmodule

@@ tb/dfbs_check.sv @@
module dfbs_check
  import dfbs_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data,
  dfbs_in_if                req,
  dfbs_out_if               rsp,
  output int                errors,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [DIM_W-1:0]          grid_w;
  logic [DIM_W-1:0]          grid_h;
  logic signed [COORD_W-1:0] org_x;
  logic signed [COORD_W-1:0] org_y;
  logic [COORD_W-1:0]        scl_x;
  logic [COORD_W-1:0]        scl_y;
  logic signed [TEXEL_W-1:0] texels [0:(1<<ADDR_W)-1];
  logic signed [TEXEL_W-1:0] distance_due [$];

  function automatic void locate(input logic signed [COORD_W-1:0] wpos,
                                 input logic signed [COORD_W-1:0] org,
                                 input logic [COORD_W-1:0] scl, input int n,
                                 output int whole, output int frac);
    longint pos;
    longint last;
    pos  = (longint'(wpos) - longint'(org)) * longint'(scl);
    last = longint'(n - 1) <<< 24;
    if (pos < 0) pos = 0;
    if (pos > last) pos = last;
    whole = int'(pos >>> 24);
    frac  = int'((pos >>> 16) & 255);
  endfunction

  function automatic longint texel_at(input int row, input int col, input int cols);
    return longint'(texels[ADDR_W'(row * cols + col)]);
  endfunction

  function automatic logic signed [TEXEL_W-1:0] predict_distance(
      input logic signed [COORD_W-1:0] wx, input logic signed [COORD_W-1:0] wy);
    int cols, rows, x0, y0, x1, y1, fx, fy;
    longint upper, lower;
    cols = (grid_w > MAX_WIDTH) ? MAX_WIDTH : int'(grid_w);
    rows = (grid_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_h);
    if (cols == 0 || rows == 0) return '0;
    locate(wx, org_x, scl_x, cols, x0, fx);
    locate(wy, org_y, scl_y, rows, y0, fy);
    x1 = (x0 + 1 < cols) ? x0 + 1 : x0;
    y1 = (y0 + 1 < rows) ? y0 + 1 : y0;
    upper = texel_at(y0, x0, cols) * (256 - fx) + texel_at(y0, x1, cols) * fx;
    lower = texel_at(y1, x0, cols) * (256 - fx) + texel_at(y1, x1, cols) * fx;
    return TEXEL_W'((upper * (256 - fy) + lower * fy + 32768) >>> 16);
  endfunction

  always @(posedge clk) begin : track
    logic signed [TEXEL_W-1:0] want;
    if (rst) begin
      grid_w = '0;
      grid_h = '0;
      org_x  = '0;
      org_y  = '0;
      scl_x  = '0;
      scl_y  = '0;
      distance_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  grid_w = cfg_data[DIM_W-1:0];
          CFG_GRID_HEIGHT: grid_h = cfg_data[DIM_W-1:0];
          CFG_ORIGIN_X:    org_x = cfg_data;
          CFG_ORIGIN_Y:    org_y = cfg_data;
          CFG_SCALE_X:     scl_x = cfg_data;
          CFG_SCALE_Y:     scl_y = cfg_data;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (distance_due.size() == 0) begin
          $error("distance beat with no sample waiting: actual %0d", rsp.distance);
          errors <= errors + 1;
        end else begin
          want = distance_due.pop_front();
          if (rsp.distance !== want) begin
            $error("distance mismatch: expected %0d, actual %0d", want, rsp.distance);
            errors <= errors + 1;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.operation == OP_WRITE) texels[req.texel_index] = req.texel_value;
        else distance_due.insert(distance_due.size(),
                                 predict_distance(req.world_x, req.world_y));
      end
    end
    outstanding <= distance_due.size();
  end

endmodule

@@ tb/testbench.sv @@
module testbench;
  import dfbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int NUM_PHASES  = 12;
  localparam int PHASE_ITEMS = 160;
  localparam int SETTLE      = 24;
  localparam int LONG_HOLD   = 400;
  localparam int STALL_LIMIT = 4000;

  typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  logic [CFG_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;
  int                errors;
  int                outstanding;

  dfbs_in_if  req ();
  dfbs_out_if rsp ();

  distance_field_bilinear_sampler #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req.sink),
    .rsp      (rsp.source)
  );

  dfbs_check #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req),
    .rsp        (rsp),
    .errors     (errors),
    .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int                        cur_w;
  int                        cur_h;
  logic signed [COORD_W-1:0] cur_ox;
  logic signed [COORD_W-1:0] cur_oy;
  logic [COORD_W-1:0]        cur_sx;
  logic [COORD_W-1:0]        cur_sy;
  bit                        written [0:(1<<ADDR_W)-1];
  int                        burst_left = 0;
  int                        items_sent = 0;
  pace_t                     tx_pace = PACE_LIGHT;
  pace_t                     rx_pace = PACE_LIGHT;
  logic                      hold_pending = 1'b0;
  int                        idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int hold_left;
    int tick;
    hold_left = 0;
    tick = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_pending && hold_left == 0) begin
        hold_left = LONG_HOLD;
        hold_pending <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        case (rx_pace)
          PACE_FULL:  rsp.ready <= 1'b1;
          PACE_LIGHT: rsp.ready <= ($urandom_range(0, 99) < 75);
          default:    rsp.ready <= ((tick % 9) >= 4);
        endcase
      end
    end
  end

  function automatic int clamp_dim(input int raw, input int limit);
    return (raw > limit) ? limit : raw;
  endfunction

  function automatic int cell_index(input logic signed [COORD_W-1:0] wpos,
                                    input logic signed [COORD_W-1:0] org,
                                    input logic [COORD_W-1:0] scl, input int n);
    longint pos;
    pos = (longint'(wpos) - longint'(org)) * longint'(scl);
    if (pos < 0) pos = 0;
    if (pos > (longint'(n - 1) <<< 24)) pos = longint'(n - 1) <<< 24;
    return int'(pos >>> 24);
  endfunction

  // Picks a world coordinate that lands near the grid, with a margin on both sides.
  function automatic logic signed [COORD_W-1:0] aim(input logic signed [COORD_W-1:0] org,
                                                    input logic [COORD_W-1:0] scl,
                                                    input int n);
    longint t;
    longint d;
    t = longint'($urandom_range(0, n * 256 + 511)) - 256;
    if (scl == 0) d = longint'($urandom_range(0, 1023)) - 512;
    else d = (t <<< 16) / longint'(scl);
    return org + COORD_W'(d);
  endfunction

  task automatic send_item(input logic op, input logic [ADDR_W-1:0] idx,
                           input logic signed [TEXEL_W-1:0] val,
                           input logic signed [COORD_W-1:0] wx,
                           input logic signed [COORD_W-1:0] wy);
    req.valid       <= 1'b1;
    req.operation   <= op;
    req.texel_index <= idx;
    req.texel_value <= val;
    req.world_x     <= wx;
    req.world_y     <= wy;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
    if (tx_pace == PACE_FULL || burst_left > 0) begin
      if (burst_left > 0) burst_left--;
    end else begin
      req.valid <= 1'b0;
      repeat (tx_pace == PACE_LIGHT ? $urandom_range(1, 4) : $urandom_range(1, 20))
        @(posedge clk);
      burst_left = (tx_pace == PACE_LIGHT) ? $urandom_range(0, 8) : $urandom_range(0, 3);
    end
  endtask

  task automatic put_texel(input int addr, input logic signed [TEXEL_W-1:0] val);
    send_item(OP_WRITE, ADDR_W'(addr), val, COORD_W'($urandom), COORD_W'($urandom));
    written[addr & 16'hFFFF] = 1'b1;
  endtask

  task automatic fill_texel(input int addr);
    if (!written[addr & 16'hFFFF]) put_texel(addr, TEXEL_W'($urandom));
  endtask

  // A sample may only touch written texels, so missing neighbors are written first.
  task automatic sample_at(input logic signed [COORD_W-1:0] wx,
                           input logic signed [COORD_W-1:0] wy);
    int cols, rows, x0, y0, x1, y1;
    cols = clamp_dim(cur_w, MAX_WIDTH);
    rows = clamp_dim(cur_h, MAX_HEIGHT);
    if (cols != 0 && rows != 0) begin
      x0 = cell_index(wx, cur_ox, cur_sx, cols);
      y0 = cell_index(wy, cur_oy, cur_sy, rows);
      x1 = (x0 + 1 < cols) ? x0 + 1 : x0;
      y1 = (y0 + 1 < rows) ? y0 + 1 : y0;
      fill_texel(y0 * cols + x0);
      fill_texel(y0 * cols + x1);
      fill_texel(y1 * cols + x0);
      fill_texel(y1 * cols + x1);
    end
    send_item(OP_SAMPLE, ADDR_W'($urandom), TEXEL_W'($urandom), wx, wy);
  endtask

  task automatic configure(input int w, input int h,
                           input logic signed [COORD_W-1:0] ox,
                           input logic signed [COORD_W-1:0] oy,
                           input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy);
    cur_w  = w;
    cur_h  = h;
    cur_ox = ox;
    cur_oy = oy;
    cur_sx = sx;
    cur_sy = sy;
    cfg_write <= 1'b1;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data  <= DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_GRID_HEIGHT;
    cfg_data  <= DATA_W'(h);
    @(posedge clk);
    cfg_index <= CFG_ORIGIN_X;
    cfg_data  <= ox;
    @(posedge clk);
    cfg_index <= CFG_ORIGIN_Y;
    cfg_data  <= oy;
    @(posedge clk);
    cfg_index <= CFG_SCALE_X;
    cfg_data  <= sx;
    @(posedge clk);
    cfg_index <= CFG_SCALE_Y;
    cfg_data  <= sy;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(257, 511);
      1:       return 256;
      2:       return 1;
      default: return $urandom_range(2, 16);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_scale();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return COORD_W'($urandom);
      3, 4:    return COORD_W'($urandom_range(4096, 1048576));
      default: return COORD_W'(65536);
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_origin();
    if ($urandom_range(0, 4) == 0) return COORD_W'($urandom);
    return COORD_W'(int'($urandom_range(0, 8191)) - 4096);
  endfunction

  initial begin : stimulus
    int                        start, cols, rows, addr, w, h;
    bit                        held;
    logic signed [COORD_W-1:0] ox, oy;
    logic [COORD_W-1:0]        sx, sy;
    rst             <= 1'b1;
    cfg_write       <= 1'b0;
    cfg_index       <= CFG_GRID_WIDTH;
    cfg_data        <= '0;
    req.valid       <= 1'b0;
    req.operation   <= OP_WRITE;
    req.texel_index <= '0;
    req.texel_value <= '0;
    req.world_x     <= '0;
    req.world_y     <= '0;
    cur_w  = 0;
    cur_h  = 0;
    cur_ox = '0;
    cur_oy = '0;
    cur_sx = '0;
    cur_sy = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    put_texel(0, 16'sh8000);
    put_texel(16'hFFFF, 16'sh7FFF);
    sample_at(24'sh800000, 24'sh7FFFFF);
    sample_at(24'sh7FFFFF, 24'sh800000);
    settle();
    configure(4, 3, '0, '0, COORD_W'(65536), COORD_W'(65536));
    for (int i = 0; i < 12; i++) put_texel(i, ((i + i / 4) % 2 == 0) ? 16'sh7FFF : 16'sh8000);
    sample_at(24'sh800000, 24'sh800000);
    sample_at(24'sh7FFFFF, 24'sh7FFFFF);
    sample_at(384, 64);
    sample_at(896, 320);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      w  = pick_dim();
      h  = pick_dim();
      ox = pick_origin();
      oy = pick_origin();
      sx = pick_scale();
      sy = pick_scale();
      case (p)
        1: begin
          w = 511;
          h = 256;
        end
        2: begin
          w = 1;
          h = 1;
        end
        3: begin
          sx = '0;
          sy = '1;
        end
        4: begin
          ox = 24'sh800000;
          oy = 24'sh7FFFFF;
        end
        5: w = 0;
        6: begin
          w = 256;
          h = 300;
        end
        8: h = 0;
        default: ;
      endcase
      configure(w, h, ox, oy, sx, sy);
      rx_pace = pace_t'(p % 3);
      tx_pace = pace_t'((p / 3) % 3);
      cols    = clamp_dim(cur_w, MAX_WIDTH);
      rows    = clamp_dim(cur_h, MAX_HEIGHT);
      start   = items_sent;
      held    = 1'b0;
      while (items_sent < start + PHASE_ITEMS) begin
        if ((p == 4 || p == 9) && !held && items_sent >= start + 40) begin
          hold_pending <= 1'b1;
          held = 1'b1;
        end
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            if (cols * rows > 0 && $urandom_range(0, 1) == 1)
              addr = $urandom_range(0, cols * rows - 1);
            else
              addr = $urandom_range(0, 65535);
            put_texel(addr, TEXEL_W'($urandom));
          end
          3:       sample_at(COORD_W'($urandom), COORD_W'($urandom));
          default: sample_at(aim(cur_ox, cur_sx, cols), aim(cur_oy, cur_sy, rows));
        endcase
      end
      settle();
    end

    if (errors == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
